// ===== design/bal_pkg.sv =====
// Shared types and constants for the bounded array list.
package bal_pkg;

    localparam int MAX_DEPTH_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int POS_W         = 8;
    localparam int CAP_W         = 5;
    localparam int OUT_IDX_W     = 5;
    localparam int OUT_CNT_W     = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Request kinds as carried on the input tuser
    typedef enum logic [2:0] {
        KIND_INSERT = 3'd0,
        KIND_APPEND = 3'd1,
        KIND_REMOVE = 3'd2,
        KIND_UPDATE = 3'd3,
        KIND_READ   = 3'd4,
        KIND_FIND   = 3'd5,
        KIND_CLEAR  = 3'd6
    } bal_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } bal_state_t;

    // What every cell of the row does on a clock edge
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_WRITE
    } bal_cell_op_t;

    typedef struct packed {
        bal_cell_op_t            op;
        logic [POS_W-1:0]        pos;
        logic [DATA_W-1:0]       value;
    } bal_cmd_t;

endpackage

// ===== design/bal_cell.sv =====
// One list entry: holds a value, shifts with its neighbours, compares for find.
module bal_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic                       clk,
    input  bal_pkg::bal_cmd_t          cmd,
    input  logic [CNT_W-1:0]           cnt,
    input  logic [bal_pkg::DATA_W-1:0] left_data,
    input  logic [bal_pkg::DATA_W-1:0] right_data,
    output logic [bal_pkg::DATA_W-1:0] entry,
    output logic                       match
);

    localparam int PW = (CNT_W > bal_pkg::POS_W) ? CNT_W : bal_pkg::POS_W;
    localparam logic [PW-1:0] IDX_P  = PW'(IDX);
    localparam logic [PW:0]   IDX_P1 = (PW + 1)'(IDX + 1);

    logic [bal_pkg::DATA_W-1:0] entry_reg;
    logic [bal_pkg::DATA_W-1:0] entry_next;
    logic [PW-1:0]              pos_ext;
    logic [PW-1:0]              cnt_ext;

    assign pos_ext = PW'(cmd.pos);
    assign cnt_ext = PW'(cnt);

    always_comb
    begin
        entry_next = entry_reg;
        case (cmd.op)
            bal_pkg::CELL_INSERT:
            begin
                if (IDX_P == pos_ext)
                    entry_next = cmd.value;
                else if (IDX_P > pos_ext && IDX_P <= cnt_ext)
                    entry_next = left_data;
            end
            bal_pkg::CELL_REMOVE:
            begin
                if (IDX_P >= pos_ext && IDX_P1 < {1'b0, cnt_ext})
                    entry_next = right_data;
            end
            bal_pkg::CELL_WRITE:
            begin
                if (IDX_P == pos_ext)
                    entry_next = cmd.value;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign match = (entry_reg == cmd.value) && (IDX_P < cnt_ext);

endmodule

// ===== design/bounded_array_list_top.sv =====
// Top level of the bounded array list: request control and the row of entry cells.
//
//  channel   dir  handshake            payload
//  s_axis    in   s_tvalid/s_tready    tuser kind, tdata position + operand_value
//  m_axis    out  m_tvalid/m_tready    tuser status, tdata read_data, found_index,
//                                      entry_count
//  cfg       in   cfg_valid/cfg_ready  cfg_data capacity
//
// A request is registered at its transfer, executed in the next cycle, in which the
// whole cell row shifts, writes and compares in parallel, and shown as a result from
// the cycle after that; the result is held while m_tready is low.
// Only one request is in flight; s_tready is high only while the block is idle.
// Reset (rst_n low) empties the list and sets the capacity to 16; the entries
// themselves are not cleared and hold whatever was last written.
// cfg_ready is always high.
module bounded_array_list_top #(
    parameter int MAX_DEPTH = bal_pkg::MAX_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] position, [39:8] operand_value
    input  logic [2:0]  s_tuser,   // [2:0] kind
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [31:0] read_data, [36:32] found_index,
                                   // [41:37] entry_count, [47:42] zero
    output logic [0:0]  m_tuser,   // [0] status
    // capacity register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data   // [4:0] capacity
);

    localparam int CW = $clog2(MAX_DEPTH + 1);
    localparam int AW = $clog2(MAX_DEPTH);
    localparam int PW = (CW > bal_pkg::POS_W) ? CW : bal_pkg::POS_W;
    localparam logic [PW-1:0] MAX_P = PW'(MAX_DEPTH);

    bal_pkg::bal_state_t state_reg, state_next;

    logic [CW-1:0]                count_reg, count_next;
    logic [bal_pkg::CAP_W-1:0]    cap_reg;
    bal_pkg::bal_kind_t           req_kind_reg;
    logic [bal_pkg::POS_W-1:0]    req_pos_reg;
    logic [bal_pkg::DATA_W-1:0]   req_value_reg;
    logic                         status_reg, status_next;
    logic [bal_pkg::DATA_W-1:0]   rdata_reg, rdata_next;
    logic [MAX_DEPTH-1:0]         match_reg;

    bal_pkg::bal_cmd_t            cmd;
    logic [bal_pkg::DATA_W-1:0]   entry_q [MAX_DEPTH];
    logic [MAX_DEPTH-1:0]         match_vec;

    logic [PW-1:0] pos_ext, cnt_ext, cap_ext, eff_cap, ins_pos;
    logic [AW-1:0] found_pos;
    logic          found_hit;
    logic [bal_pkg::OUT_IDX_W-1:0] found_index;

    // -------- sequencing: take a request, run it through the row, show the result
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bal_pkg::ST_IDLE: if (s_tvalid) state_next = bal_pkg::ST_EXEC;
            bal_pkg::ST_EXEC: state_next = bal_pkg::ST_RESP;
            bal_pkg::ST_RESP: if (m_tready) state_next = bal_pkg::ST_IDLE;
            default:          state_next = bal_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = (state_reg == bal_pkg::ST_IDLE);
        m_tvalid = (state_reg == bal_pkg::ST_RESP);
    end

    assign cfg_ready = 1'b1;

    // -------- request decode, only acted on in the execute cycle
    assign pos_ext = PW'(req_pos_reg);
    assign cnt_ext = PW'(count_reg);
    assign cap_ext = PW'(cap_reg);
    assign eff_cap = (cap_ext > MAX_P) ? MAX_P : cap_ext;
    assign ins_pos = (req_kind_reg == bal_pkg::KIND_APPEND) ? cnt_ext : pos_ext;

    always_comb
    begin
        cmd.op      = bal_pkg::CELL_HOLD;
        cmd.pos     = req_pos_reg;
        cmd.value   = req_value_reg;
        count_next  = count_reg;
        status_next = 1'b0;
        rdata_next  = '0;
        case (req_kind_reg) inside
            bal_pkg::KIND_INSERT, bal_pkg::KIND_APPEND:
            begin
                // reject when full or when the slot would leave a gap
                if (cnt_ext >= eff_cap || ins_pos > cnt_ext)
                    status_next = 1'b1;
                else
                begin
                    cmd.op     = bal_pkg::CELL_INSERT;
                    cmd.pos    = ins_pos[bal_pkg::POS_W-1:0];
                    count_next = count_reg + CW'(1);
                end
            end
            bal_pkg::KIND_REMOVE:
            begin
                if (pos_ext >= cnt_ext)
                    status_next = 1'b1;
                else
                begin
                    cmd.op     = bal_pkg::CELL_REMOVE;
                    count_next = count_reg - CW'(1);
                end
            end
            bal_pkg::KIND_UPDATE:
            begin
                if (pos_ext >= cnt_ext)
                    status_next = 1'b1;
                else
                    cmd.op = bal_pkg::CELL_WRITE;
            end
            bal_pkg::KIND_READ:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    status_next = 1'b1;
                    rdata_next  = '1;
                end
                else
                    rdata_next = entry_q[pos_ext[AW-1:0]];
            end
            bal_pkg::KIND_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                // find is resolved from the registered match vector; nothing else to do
                status_next = 1'b0;
            end
        endcase
        // hold everything outside the execute cycle
        if (state_reg != bal_pkg::ST_EXEC)
        begin
            cmd.op     = bal_pkg::CELL_HOLD;
            count_next = count_reg;
        end
    end

    // -------- the row of entry cells
    for (genvar i = 0; i < MAX_DEPTH; i++)
    begin : g_cell
        logic [bal_pkg::DATA_W-1:0] left_d, right_d;
        if (i == 0)
        begin : g_first
            assign left_d = req_value_reg;
        end
        else
        begin : g_left
            assign left_d = entry_q[i-1];
        end
        if (i == MAX_DEPTH - 1)
        begin : g_last
            assign right_d = req_value_reg;
        end
        else
        begin : g_right
            assign right_d = entry_q[i+1];
        end

        bal_cell #(
            .IDX   (i),
            .CNT_W (CW)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .cnt        (count_reg),
            .left_data  (left_d),
            .right_data (right_d),
            .entry      (entry_q[i]),
            .match      (match_vec[i])
        );
    end

    // -------- first match, from the lowest position
    always_comb
    begin
        found_pos = '0;
        found_hit = 1'b0;
        for (int i = MAX_DEPTH - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                found_pos = AW'(i);
                found_hit = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (req_kind_reg != bal_pkg::KIND_FIND)
            found_index = '0;
        else if (found_hit)
            found_index = bal_pkg::OUT_IDX_W'(found_pos);
        else
            found_index = '1;
    end

    // -------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bal_pkg::ST_IDLE;
            count_reg <= '0;
            cap_reg   <= bal_pkg::CAP_RESET;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_ready)
                cap_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            req_kind_reg  <= bal_pkg::bal_kind_t'(s_tuser[2:0]);
            req_pos_reg   <= s_tdata[7:0];
            req_value_reg <= s_tdata[39:8];
        end
        if (state_reg == bal_pkg::ST_EXEC)
        begin
            status_reg <= status_next;
            rdata_reg  <= rdata_next;
            match_reg  <= match_vec;
        end
    end

    assign m_tuser[0] = status_reg;
    assign m_tdata    = {6'd0, bal_pkg::OUT_CNT_W'(count_reg), found_index, rdata_reg};

endmodule

// ===== design/bal_checker.sv =====
// Port-level checks for the bounded array list, bound to the top level.
module bal_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // one request in flight: never take a request while a result is shown
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input taken while a result is pending");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready stayed high after an input transfer");

    a_drop_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready) |=> !m_tvalid)
        else $error("result repeated after its transfer");

    // a rejected request is never a find, so its found_index is zero
    a_reject_no_find: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[36:32] == 5'd0))
        else $error("rejected result carries a found index");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind bounded_array_list_top bal_checker u_bal_checker (.*);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the bounded array list: driver, predictor and result monitor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Kind code that the block has no operation for
    localparam logic [2:0] KIND_UNUSED = 3'd7;

    // Idle cycles the driver waits, with nothing in flight, before a capacity write or the end of a drain
    localparam int QUIET_CYCLES = 4;

    // Accepted-item counts at which the idling pattern changes
    localparam int SWAP_AT   = 290;
    localparam int CALM_AT   = 580;

    // Hard stop: far beyond the slowest legal run of some 850 requests
    localparam int RUN_LIMIT_NS = 2_000_000;

    // What a queued entry asks the driver to do
    typedef enum logic [1:0] {
        ACT_ITEM,
        ACT_CFG,
        ACT_DRAIN
    } act_kind_t;

    // How the driver chooses the position when it presents the request
    typedef enum logic [1:0] {
        POS_FIXED,  // as written in the entry
        POS_HELD,   // an occupied slot (0 on an empty list)
        POS_END,    // the current count, one past the last entry
        POS_WILD    // anything in the 8-bit range
    } pos_pick_t;

    typedef struct {
        act_kind_t   act;
        logic [2:0]  kind;
        pos_pick_t   pick;
        logic [7:0]  pos;
        logic [31:0] value;
        bit          from_list;  // search for a value already stored
        logic [4:0]  cap;
    } list_req_t;

    typedef struct packed {
        logic        status;
        logic [31:0] read_data;
        logic [4:0]  found_index;
        logic [4:0]  entry_count;
    } list_reply_t;

    // ------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;   // [7:0] position, [39:8] operand_value
    logic [2:0]  s_tuser   = '0;   // [2:0] kind
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;          // [31:0] read_data, [36:32] found_index,
                                   // [41:37] entry_count
    logic [0:0]  m_tuser;          // [0] status
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data  = '0;   // [4:0] capacity

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    bounded_array_list_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Shadow of the list and the bookkeeping around it
    // ------------------------------------------------------------------
    logic [31:0] list_entries [bal_pkg::MAX_DEPTH_DEF];
    logic [4:0]  list_count;
    logic [4:0]  list_cap;

    list_req_t   queued_requests [$];
    list_reply_t awaited_replies [$];

    int idle_phase   = 0;   // 0: sender 33 / receiver 51, 1: swapped, 2: no idling
    int quiet_cnt    = 0;
    int sent_count   = 0;
    int reply_count  = 0;
    int reject_count = 0;
    int cfg_writes   = 0;
    int error_count  = 0;

    // Work out the reply to one request and move the shadow list on.
    function automatic void apply_list_request(logic [2:0] kind, logic [7:0] pos,
                                               logic [31:0] val);
        list_reply_t rep;
        int lim;
        int n;
        int p;
        int i;
        rep = '0;
        // Register values above the store depth saturate; zero means always full
        lim = (int'(list_cap) > bal_pkg::MAX_DEPTH_DEF) ? bal_pkg::MAX_DEPTH_DEF
                                                        : int'(list_cap);
        n   = int'(list_count);
        p   = int'(pos);
        case (kind)
            bal_pkg::KIND_INSERT, bal_pkg::KIND_APPEND:
            begin
                if (kind == bal_pkg::KIND_APPEND)
                    p = n;
                if (n >= lim || p > n)
                    rep.status = 1'b1;
                else
                begin
                    for (i = n; i > p; i--)
                        list_entries[i] = list_entries[i-1];
                    list_entries[p] = val;
                    n++;
                end
            end
            bal_pkg::KIND_REMOVE:
            begin
                if (p >= n)
                    rep.status = 1'b1;
                else
                begin
                    for (i = p; i + 1 < n; i++)
                        list_entries[i] = list_entries[i+1];
                    n--;
                end
            end
            bal_pkg::KIND_UPDATE:
            begin
                if (p >= n)
                    rep.status = 1'b1;
                else
                    list_entries[p] = val;
            end
            bal_pkg::KIND_READ:
            begin
                if (p >= n)
                begin
                    rep.status    = 1'b1;
                    rep.read_data = '1;
                end
                else
                    rep.read_data = list_entries[p];
            end
            bal_pkg::KIND_FIND:
            begin
                // Scan downwards so that the lowest matching slot wins
                rep.found_index = '1;
                for (i = n - 1; i >= 0; i--)
                    if (list_entries[i] == val)
                        rep.found_index = 5'(i);
            end
            bal_pkg::KIND_CLEAR:
                n = 0;
            default:
                ;
        endcase
        list_count      = 5'(n);
        rep.entry_count = list_count;
        if (rep.status)
            reject_count++;
        awaited_replies.push_back(rep);
    endfunction

    // ------------------------------------------------------------------
    // Building the request list
    // ------------------------------------------------------------------
    function automatic void add_item(logic [2:0] kind, pos_pick_t pick, logic [7:0] pos,
                                     logic [31:0] value, bit from_list);
        list_req_t req;
        req.act       = ACT_ITEM;
        req.kind      = kind;
        req.pick      = pick;
        req.pos       = pos;
        req.value     = value;
        req.from_list = from_list;
        req.cap       = '0;
        queued_requests.push_back(req);
    endfunction

    function automatic void add_cfg(logic [4:0] cap);
        list_req_t req;
        req.act       = ACT_CFG;
        req.kind      = '0;
        req.pick      = POS_FIXED;
        req.pos       = '0;
        req.value     = '0;
        req.from_list = 1'b0;
        req.cap       = cap;
        queued_requests.push_back(req);
    endfunction

    function automatic void add_drain();
        list_req_t req;
        req.act       = ACT_DRAIN;
        req.kind      = '0;
        req.pick      = POS_FIXED;
        req.pos       = '0;
        req.value     = '0;
        req.from_list = 1'b0;
        req.cap       = '0;
        queued_requests.push_back(req);
    endfunction

    // Small values dominate so that finds hit and duplicates are common
    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 32'($urandom_range(0, 7));
        if (r < 50)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'hFFFF_FFFF;
                default: return 32'h0000_0000;
            endcase
        end
        return $urandom;
    endfunction

    function automatic pos_pick_t pick_slot();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return POS_HELD;
        if (r < 90)
            return POS_END;
        return POS_WILD;
    endfunction

    // A run of random requests, mostly well-formed, with a full drain halfway
    function automatic void add_random_run(int n);
        int i;
        int r;
        for (i = 0; i < n; i++)
        begin
            if (i == n / 2)
                add_drain();
            r = $urandom_range(0, 99);
            if (r < 18)
                add_item(bal_pkg::KIND_INSERT, pick_slot(), '0, pick_value(), 1'b0);
            else if (r < 36)
                add_item(bal_pkg::KIND_APPEND, POS_WILD, '0, pick_value(), 1'b0);
            else if (r < 52)
                add_item(bal_pkg::KIND_REMOVE, pick_slot(), '0, pick_value(), 1'b0);
            else if (r < 62)
                add_item(bal_pkg::KIND_UPDATE, pick_slot(), '0, pick_value(), 1'b0);
            else if (r < 77)
                add_item(bal_pkg::KIND_READ, pick_slot(), '0, pick_value(), 1'b0);
            else if (r < 92)
                add_item(bal_pkg::KIND_FIND, POS_WILD, '0, pick_value(),
                         $urandom_range(0, 99) < 60);
            else if (r < 95)
                add_item(bal_pkg::KIND_CLEAR, POS_WILD, '0, $urandom, 1'b0);
            else if (r < 97)
                add_item(KIND_UNUSED, POS_WILD, '0, $urandom, 1'b0);
            else
                add_item(3'($urandom_range(0, 7)), POS_WILD, '0, $urandom, 1'b0);
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: present requests and capacity writes, predict on transfer
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        list_req_t   req;
        logic [7:0]  pos_now;
        logic [31:0] val_now;
        int          send_idle;
        int          i;
        if (!rst_n)
        begin
            s_tvalid  <= 1'b0;
            cfg_valid <= 1'b0;
            for (i = 0; i < bal_pkg::MAX_DEPTH_DEF; i++)
                list_entries[i] = '0;
            list_count = '0;
            list_cap   = bal_pkg::CAP_RESET;
            quiet_cnt  = 0;
        end
        else
        begin
            // Predict from the values that were on the bus during this transfer
            if (s_tvalid && s_tready)
            begin
                apply_list_request(s_tuser, s_tdata[7:0], s_tdata[39:8]);
                sent_count++;
            end
            if (cfg_valid && cfg_ready)
            begin
                list_cap = cfg_data;
                cfg_writes++;
            end

            if (awaited_replies.size() == 0 && !m_tvalid && !s_tvalid && !cfg_valid)
                quiet_cnt++;
            else
                quiet_cnt = 0;

            idle_phase <= (sent_count < SWAP_AT) ? 0 : (sent_count < CALM_AT) ? 1 : 2;
            send_idle  = (idle_phase == 0) ? 33 : (idle_phase == 1) ? 51 : 0;

            if (s_tvalid && !s_tready)
            begin
                // hold the request until the block takes it
            end
            else if (cfg_valid && !cfg_ready)
            begin
                // hold the capacity write
            end
            else if (queued_requests.size() == 0)
            begin
                s_tvalid  <= 1'b0;
                cfg_valid <= 1'b0;
            end
            else
            begin
                req = queued_requests[0];
                case (req.act)
                    ACT_ITEM:
                    begin
                        cfg_valid <= 1'b0;
                        if ($urandom_range(0, 99) < send_idle)
                            s_tvalid <= 1'b0;
                        else
                        begin
                            // Resolve position and search value against the list as it is now
                            case (req.pick)
                                POS_HELD:
                                    pos_now = (list_count == 0) ? 8'd0 :
                                              8'($urandom_range(0, int'(list_count) - 1));
                                POS_END:  pos_now = 8'(list_count);
                                POS_WILD: pos_now = 8'($urandom_range(0, 255));
                                default:  pos_now = req.pos;
                            endcase
                            if (req.from_list && list_count != 0)
                                val_now = list_entries[$urandom_range(0, int'(list_count) - 1)];
                            else
                                val_now = req.value;
                            s_tuser  <= req.kind;
                            s_tdata  <= {val_now, pos_now};
                            s_tvalid <= 1'b1;
                            void'(queued_requests.pop_front());
                        end
                    end
                    ACT_CFG:
                    begin
                        // Write the capacity only once the block has gone quiet
                        s_tvalid <= 1'b0;
                        if (quiet_cnt >= QUIET_CYCLES)
                        begin
                            cfg_data  <= req.cap;
                            cfg_valid <= 1'b1;
                            void'(queued_requests.pop_front());
                        end
                        else
                            cfg_valid <= 1'b0;
                    end
                    default:
                    begin
                        // Drain: stop sending until every reply is back
                        s_tvalid  <= 1'b0;
                        cfg_valid <= 1'b0;
                        if (quiet_cnt >= QUIET_CYCLES)
                            void'(queued_requests.pop_front());
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare every reply with the oldest prediction
    // ------------------------------------------------------------------
    function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected 0x%08h, actual 0x%08h",
                     $time, what, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : check_replies
        list_reply_t want;
        int          recv_idle;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                reply_count++;
                if (awaited_replies.size() == 0)
                begin
                    $display("%0t ns: reply with none expected, actual tuser 0x%0h tdata 0x%012h",
                             $time, m_tuser, m_tdata);
                    error_count++;
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    check_field("status",      32'(want.status),      32'(m_tuser[0]));
                    check_field("read_data",   want.read_data,        m_tdata[31:0]);
                    check_field("found_index", 32'(want.found_index), 32'(m_tdata[36:32]));
                    check_field("entry_count", 32'(want.entry_count), 32'(m_tdata[41:37]));
                end
            end
            recv_idle = (idle_phase == 0) ? 51 : (idle_phase == 1) ? 33 : 0;
            m_tready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        // Directed part at the reset capacity of 16: rejections and a missed find on an empty list first
        add_item(bal_pkg::KIND_READ,   POS_FIXED, 8'd0,   32'h0000_0000, 1'b0);
        add_item(bal_pkg::KIND_REMOVE, POS_FIXED, 8'd0,   32'h0000_0000, 1'b0);
        add_item(bal_pkg::KIND_UPDATE, POS_FIXED, 8'd0,   32'h0000_0001, 1'b0);
        add_item(bal_pkg::KIND_FIND,   POS_FIXED, 8'd0,   32'h0000_0000, 1'b0);
        add_item(bal_pkg::KIND_INSERT, POS_FIXED, 8'd1,   32'h0000_0005, 1'b0);
        // Build a list of extremes: front, end, middle and at-count inserts, a refused far insert, reads and a find
        add_item(bal_pkg::KIND_INSERT, POS_FIXED, 8'd0,   32'h7FFF_FFFF, 1'b0);
        add_item(bal_pkg::KIND_APPEND, POS_FIXED, 8'd200, 32'h8000_0000, 1'b0);
        add_item(bal_pkg::KIND_INSERT, POS_FIXED, 8'd1,   32'hFFFF_FFFF, 1'b0);
        add_item(bal_pkg::KIND_INSERT, POS_FIXED, 8'd3,   32'h0000_0000, 1'b0);
        add_item(bal_pkg::KIND_INSERT, POS_FIXED, 8'd255, 32'h1234_5678, 1'b0);
        add_item(bal_pkg::KIND_READ,   POS_FIXED, 8'd0,   32'h0000_0000, 1'b0);
        add_item(bal_pkg::KIND_READ,   POS_FIXED, 8'd3,   32'h0000_0000, 1'b0);
        add_item(bal_pkg::KIND_READ,   POS_FIXED, 8'd4,   32'h0000_0000, 1'b0);
        add_item(bal_pkg::KIND_READ,   POS_FIXED, 8'd255, 32'hFFFF_FFFF, 1'b0);
        add_item(bal_pkg::KIND_FIND,   POS_FIXED, 8'd255, 32'h8000_0000, 1'b0);
        // Duplicate a value so that find must report the first one
        add_item(bal_pkg::KIND_UPDATE, POS_FIXED, 8'd3,   32'hFFFF_FFFF, 1'b0);
        add_item(bal_pkg::KIND_FIND,   POS_FIXED, 8'd0,   32'hFFFF_FFFF, 1'b0);
        add_item(bal_pkg::KIND_UPDATE, POS_FIXED, 8'd255, 32'h5555_5555, 1'b0);
        add_item(bal_pkg::KIND_REMOVE, POS_FIXED, 8'd0,   32'h0000_0000, 1'b0);
        add_item(bal_pkg::KIND_REMOVE, POS_FIXED, 8'd3,   32'h0000_0000, 1'b0);
        add_item(KIND_UNUSED,          POS_FIXED, 8'd255, 32'hFFFF_FFFF, 1'b0);
        add_item(bal_pkg::KIND_CLEAR,  POS_FIXED, 8'd255, 32'hAAAA_AAAA, 1'b0);
        add_item(bal_pkg::KIND_READ,   POS_FIXED, 8'd0,   32'h0000_0000, 1'b0);
        // Capacity of one: second entry is refused as full
        add_cfg(5'd1);
        add_item(bal_pkg::KIND_APPEND, POS_FIXED, 8'd0,   32'h0000_0011, 1'b0);
        add_item(bal_pkg::KIND_APPEND, POS_FIXED, 8'd0,   32'h0000_0022, 1'b0);
        add_item(bal_pkg::KIND_INSERT, POS_FIXED, 8'd0,   32'h0000_0033, 1'b0);
        // Capacity of zero, lowered below the count: entry stays readable, no inserts
        add_cfg(5'd0);
        add_item(bal_pkg::KIND_READ,   POS_FIXED, 8'd0,   32'h0000_0000, 1'b0);
        add_item(bal_pkg::KIND_APPEND, POS_FIXED, 8'd0,   32'h0000_0044, 1'b0);
        add_item(bal_pkg::KIND_REMOVE, POS_FIXED, 8'd0,   32'h0000_0000, 1'b0);
        add_item(bal_pkg::KIND_APPEND, POS_FIXED, 8'd0,   32'h0000_0055, 1'b0);

        // Random runs across a spread of capacities, saturating values included
        add_cfg(5'd16);
        add_random_run(120);
        add_cfg(5'd31);
        add_random_run(120);
        add_cfg(5'($urandom_range(2, 15)));
        add_random_run(120);
        add_cfg(5'd4);
        add_random_run(120);
        add_cfg(5'd1);
        add_random_run(100);
        add_cfg(5'($urandom_range(0, 31)));
        add_random_run(120);
        add_cfg(5'd16);
        add_random_run(120);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for the queue to empty and every reply to come back
        while (queued_requests.size() != 0 || s_tvalid || cfg_valid ||
               awaited_replies.size() != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);

        if (awaited_replies.size() != 0)
        begin
            $display("%0t ns: %0d replies never arrived", $time, awaited_replies.size());
            error_count++;
        end

        $display("Sent %0d list requests (%0d refused) over %0d capacity writes,",
                 sent_count, reject_count, cfg_writes);
        $display("checked %0d replies with %0d errors.", reply_count, error_count);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Timed out with %0d requests queued and %0d replies outstanding",
                 queued_requests.size(), awaited_replies.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
